FILE: hdl/fbc_pkg.sv
// Shared types and constants for the frustum box culling block.
`timescale 1ns / 1ps

package fbc_pkg;

  localparam int NUM_PLANES_DEF = 6;
  localparam int CORNER_COUNT   = 8;
  localparam int STEP_COUNT     = 6;   // lo/hi coordinate per axis
  localparam int COORD_W        = 32;
  localparam int NORM_W         = 16;
  localparam int PROD_W         = 48;
  localparam int SUM_W          = 50;
  localparam int NORM_FRAC      = 14;

  localparam logic OPC_LOAD = 1'b0;
  localparam logic OPC_TEST = 1'b1;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic                       valid;
    logic [1:0]                 axis;
    logic                       hi;
    logic signed [COORD_W-1:0]  coord;
  } fbc_token_t;

  typedef struct packed {
    logic signed [NORM_W-1:0]   nx;
    logic signed [NORM_W-1:0]   ny;
    logic signed [NORM_W-1:0]   nz;
    logic signed [COORD_W-1:0]  offset;
  } fbc_plane_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic signed [COORD_W-1:0]  z;
  } fbc_vec_t;

endpackage

FILE: hdl/frustum_box_culling.sv
// Top level of the frustum box culling block: handshake, plane chain, result buffer.
`timescale 1ns / 1ps

// A load request writes one plane into its cell in the cycle it is accepted and
// gives no result; loads are held off while a box test is still in the chain. A
// test request is streamed as six coordinate tokens (lo and hi per axis) through
// a chain of NUM_PLANES cells, one cell per plane, each with one 16x32
// multiplier; tokens move one cell per cycle and each cell's culled verdict
// joins its neighbor's as the tokens pass. rsp_valid rises once the last cell's
// verdict enters the result buffer. A new test is accepted only once the feeder
// has streamed the tokens of the last one, and at most two tests sit in the
// chain and the two-entry output buffer together, so a third test waits until
// one of their results is taken.

module frustum_box_culling import fbc_pkg::*; #(
  parameter int NUM_PLANES = NUM_PLANES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  logic                      opcode,
  input  logic [2:0]                plane_index,
  input  logic signed [NORM_W-1:0]  normal_x,
  input  logic signed [NORM_W-1:0]  normal_y,
  input  logic signed [NORM_W-1:0]  normal_z,
  input  logic signed [COORD_W-1:0] plane_offset,
  input  logic signed [COORD_W-1:0] box_min_x,
  input  logic signed [COORD_W-1:0] box_min_y,
  input  logic signed [COORD_W-1:0] box_min_z,
  input  logic signed [COORD_W-1:0] box_max_x,
  input  logic signed [COORD_W-1:0] box_max_y,
  input  logic signed [COORD_W-1:0] box_max_z,
  output logic                      rsp_valid,
  input  logic                      rsp_ready,
  output logic                      visible
);

  fbc_token_t             tok [NUM_PLANES];
  logic [NUM_PLANES:0]    culled;
  logic [NUM_PLANES-1:0]  wr_en;
  fbc_plane_t             wr_plane;
  fbc_vec_t               box_lo;
  fbc_vec_t               box_hi;
  logic                   feed_busy;
  logic                   done_last;
  logic                   req_acc;
  logic                   test_acc;
  logic                   load_acc;
  logic                   rsp_acc;

  logic [1:0]             inflight;
  logic [1:0]             count;
  logic                   q0;
  logic                   q1;

  assign req_ready = !feed_busy &&
                     ((opcode == OPC_TEST) ? ((3'(inflight) + 3'(count)) < 3'd2)
                                           : (inflight == 2'd0));
  assign req_acc   = req_valid && req_ready;
  assign test_acc  = req_acc && (opcode == OPC_TEST);
  assign load_acc  = req_acc && (opcode == OPC_LOAD);
  assign rsp_acc   = rsp_valid && rsp_ready;

  assign wr_plane = '{nx: normal_x, ny: normal_y, nz: normal_z, offset: plane_offset};
  assign box_lo   = '{x: box_min_x, y: box_min_y, z: box_min_z};
  assign box_hi   = '{x: box_max_x, y: box_max_y, z: box_max_z};

  fbc_feed u_feed (
    .clk    (clk),
    .rst    (rst),
    .start  (test_acc),
    .box_lo (box_lo),
    .box_hi (box_hi),
    .tok    (tok[0]),
    .busy   (feed_busy)
  );

  assign culled[0] = 1'b0;

  for (genvar k = 0; k < NUM_PLANES; k++) begin : g_cell
    // out-of-range indexes match no cell and are dropped
    assign wr_en[k] = load_acc && ({29'd0, plane_index} == 32'(k));

    if (k < NUM_PLANES - 1) begin : g_mid
      fbc_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .wr_en      (wr_en[k]),
        .wr_plane   (wr_plane),
        .tok_in     (tok[k]),
        .tok_out    (tok[k+1]),
        .culled_in  (culled[k]),
        .culled_out (culled[k+1]),
        .done_out   ()
      );
    end else begin : g_last
      fbc_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .wr_en      (wr_en[k]),
        .wr_plane   (wr_plane),
        .tok_in     (tok[k]),
        .tok_out    (),
        .culled_in  (culled[k]),
        .culled_out (culled[k+1]),
        .done_out   (done_last)
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + {1'b0, test_acc} - {1'b0, done_last};
    end
  end

  // two-entry result buffer; credits on accept keep it from overflowing
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count + {1'b0, done_last} - {1'b0, rsp_acc};
    end
  end

  always_ff @(posedge clk) begin
    case (count)
      2'd0: begin
        if (done_last) begin
          q0 <= !culled[NUM_PLANES];
        end
      end
      2'd1: begin
        if (done_last && rsp_acc) begin
          q0 <= !culled[NUM_PLANES];
        end else if (done_last) begin
          q1 <= !culled[NUM_PLANES];
        end
      end
      2'd2: begin
        if (rsp_acc) begin
          q0 <= q1;
        end
      end
      default: begin
      end
    endcase
  end

  assign rsp_valid = (count != 2'd0);
  assign visible   = q0;

endmodule

FILE: hdl/fbc_feed.sv
// Token feeder: streams the six box coordinates into the plane cell chain.
`timescale 1ns / 1ps

module fbc_feed import fbc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  fbc_vec_t   box_lo,
  input  fbc_vec_t   box_hi,
  output fbc_token_t tok,
  output logic       busy
);

  fbc_vec_t   lo;
  fbc_vec_t   hi;
  logic [2:0] step;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      if (step == 3'(STEP_COUNT - 1)) begin
        busy <= 1'b0;
      end
      step <= step + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      lo <= box_lo;
      hi <= box_hi;
    end
  end

  // order: x lo, x hi, y lo, y hi, z lo, z hi
  always_comb begin
    tok.valid = busy;
    tok.axis  = step[2:1];
    tok.hi    = step[0];
    case (step[2:1])
      AXIS_X:  tok.coord = step[0] ? hi.x : lo.x;
      AXIS_Y:  tok.coord = step[0] ? hi.y : lo.y;
      AXIS_Z:  tok.coord = step[0] ? hi.z : lo.z;
      default: tok.coord = '0;
    endcase
  end

endmodule

FILE: hdl/fbc_cell.sv
// One plane cell: holds a plane, tests the box corner with the least dot, forwards tokens.
`timescale 1ns / 1ps

module fbc_cell import fbc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  fbc_plane_t wr_plane,
  input  fbc_token_t tok_in,
  output fbc_token_t tok_out,
  input  logic       culled_in,
  output logic       culled_out,
  output logic       done_out
);

  fbc_plane_t               plane;

  logic                     p_valid;
  logic                     p_hi;
  logic                     p_first;
  logic                     p_last;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] lo_prod;

  logic                     m_valid;
  logic                     m_first;
  logic                     m_last;
  logic signed [PROD_W-1:0] m;
  logic signed [SUM_W-1:0]  acc;

  logic signed [NORM_W-1:0]  norm_sel;
  logic signed [COORD_W-1:0] coord_s;
  logic signed [COORD_W-1:0] off_s;
  logic signed [PROD_W-1:0]  prod_next;
  logic signed [PROD_W-1:0]  m_next;
  logic signed [SUM_W-1:0]   sum;
  logic signed [SUM_W-1:0]   lim;
  logic                      outside;

  always_comb begin
    case (tok_in.axis)
      AXIS_X:  norm_sel = plane.nx;
      AXIS_Y:  norm_sel = plane.ny;
      AXIS_Z:  norm_sel = plane.nz;
      default: norm_sel = '0;
    endcase
  end

  assign coord_s   = tok_in.coord;
  assign prod_next = PROD_W'(norm_sel) * PROD_W'(coord_s);
  // the eight corners are all outside iff the one with the least dot is
  assign m_next    = (prod < lo_prod) ? prod : lo_prod;
  assign off_s     = plane.offset;
  assign sum       = m_first ? SUM_W'(m) : acc + SUM_W'(m);
  assign lim       = SUM_W'(off_s) <<< NORM_FRAC;
  assign outside   = (sum >= lim);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      plane <= wr_plane;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
      p_valid       <= 1'b0;
      m_valid       <= 1'b0;
      done_out      <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
      p_valid       <= tok_in.valid;
      m_valid       <= p_valid && p_hi;
      done_out      <= m_valid && m_last;
    end
  end

  always_ff @(posedge clk) begin
    tok_out.axis  <= tok_in.axis;
    tok_out.hi    <= tok_in.hi;
    tok_out.coord <= tok_in.coord;
    prod          <= prod_next;
    p_hi          <= tok_in.hi;
    p_first       <= (tok_in.axis == AXIS_X);
    p_last        <= (tok_in.axis == AXIS_Z);
    if (p_valid && !p_hi) begin
      lo_prod <= prod;
    end
    m       <= m_next;
    m_first <= p_first;
    m_last  <= p_last;
    if (m_valid) begin
      acc <= sum;
    end
    // the neighbor's verdict lands in the same cycle this cell decides
    if (m_valid && m_last) begin
      culled_out <= culled_in | outside;
    end
  end

endmodule
